// ----- design/pwbd_pkg.sv -----
// ----------------------------------------------------------------------------
// pwbd_pkg
// Types and constants shared by the pulse width bit decoder modules.
// ----------------------------------------------------------------------------
package pwbd_pkg;

   localparam int unsigned TIME_W      = 32;
   localparam int unsigned TIMER_W     = 16;
   localparam int unsigned FRAME_W     = 64;
   localparam int unsigned COUNT_W     = 6;
   localparam int unsigned POS_W       = 7;
   localparam int unsigned MS_MULT_W   = 10;

   localparam logic [MS_MULT_W-1:0] US_PER_MS    = MS_MULT_W'(1000);
   localparam logic [TIMER_W-1:0]   RELOAD_RESET = TIMER_W'(50000);
   localparam logic [COUNT_W-1:0]   COUNT_MAX    = '1;
   localparam logic [POS_W-1:0]     FRAME_LIMIT  = POS_W'(FRAME_W);

   typedef enum logic [1:0] {
      ACT_RISE    = 2'd0,
      ACT_FALL    = 2'd1,
      ACT_TIMEOUT = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef struct packed {
      logic              drain;
      logic [TIME_W-1:0] width;
   } cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_THR,
      S_SCAN,
      S_DONE
   } back_state_type;

endpackage

// ----- design/pwbd_ram.sv -----
// ----------------------------------------------------------------------------
// pwbd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pwbd_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/pwbd_front.sv -----
// ----------------------------------------------------------------------------
// pwbd_front
// Forms edge timestamps and deltas, classifies each item into a width push,
// a frame drain or nothing, and hands commands to the queue.
// ----------------------------------------------------------------------------
module pwbd_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [pwbd_pkg::TIMER_W-1:0]    timer_reload,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [1:0]                      in_action,
   input  logic [pwbd_pkg::TIME_W-1:0]     in_coarse_ms,
   input  logic [pwbd_pkg::TIMER_W-1:0]    in_timer_count,
   output logic                            cmd_valid,
   input  logic                            cmd_ready,
   output pwbd_pkg::cmd_type               cmd
);

   logic                            s1_valid_ff, s1_valid_in;
   pwbd_pkg::action_type            s1_action_ff;
   logic [pwbd_pkg::TIME_W-1:0]     s1_prod_ff;
   logic [pwbd_pkg::TIME_W-1:0]     s1_frac_ff;
   logic [pwbd_pkg::TIME_W-1:0]     last_ff, last_in;
   logic                            seen_ff, seen_in;
   logic [pwbd_pkg::TIME_W-1:0]     stamp;
   logic [pwbd_pkg::TIME_W-1:0]     delta;
   logic                            is_edge;
   logic                            needs_cmd;
   logic                            s1_fire;
   logic                            take;

   assign stamp     = s1_prod_ff + s1_frac_ff;
   assign delta     = seen_ff ? (stamp - last_ff) : '0;
   assign is_edge   = (s1_action_ff == pwbd_pkg::ACT_RISE) ||
                      (s1_action_ff == pwbd_pkg::ACT_FALL);
   assign needs_cmd = (s1_action_ff == pwbd_pkg::ACT_FALL) ||
                      (s1_action_ff == pwbd_pkg::ACT_TIMEOUT);
   assign s1_fire   = s1_valid_ff && (!needs_cmd || cmd_ready);
   assign in_ready  = !s1_valid_ff || s1_fire;
   assign take      = in_valid && in_ready;

   assign cmd_valid = s1_valid_ff && needs_cmd;
   assign cmd.drain = (s1_action_ff == pwbd_pkg::ACT_TIMEOUT);
   assign cmd.width = delta;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      last_in     = last_ff;
      seen_in     = seen_ff;
      if (s1_fire) begin
         s1_valid_in = 1'b0;
         if (is_edge) begin
            last_in = stamp;
            seen_in = 1'b1;
         end
      end
      if (take) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         last_ff     <= '0;
         seen_ff     <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         last_ff     <= last_in;
         seen_ff     <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_action_ff <= pwbd_pkg::action_type'(in_action);
         s1_prod_ff   <= pwbd_pkg::TIME_W'(in_coarse_ms * pwbd_pkg::US_PER_MS);
         s1_frac_ff   <= pwbd_pkg::TIME_W'(timer_reload) -
                         pwbd_pkg::TIME_W'(in_timer_count);
      end
   end

endmodule

// ----- design/pwbd_queue.sv -----
// ----------------------------------------------------------------------------
// pwbd_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module pwbd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  pwbd_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop,
   output pwbd_pkg::cmd_type pop_cmd
);

   pwbd_pkg::cmd_type slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- design/pwbd_back.sv -----
// ----------------------------------------------------------------------------
// pwbd_back
// Keeps the width ring, pushes widths and drains the ring into one frame,
// classifying each width against the threshold from the first one.
// ----------------------------------------------------------------------------
module pwbd_back #(
   parameter int unsigned RING_DEPTH = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_valid,
   input  pwbd_pkg::cmd_type               cmd,
   output logic                            cmd_pop,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [pwbd_pkg::FRAME_W-1:0]    out_frame_bits,
   output logic [pwbd_pkg::COUNT_W-1:0]    out_bit_count,
   output logic [pwbd_pkg::TIME_W-1:0]     out_threshold_us
);

   localparam int unsigned ADDR_W = $clog2(RING_DEPTH);
   localparam int unsigned FILL_W = $clog2(RING_DEPTH + 1);
   localparam int unsigned SUM_W  = FILL_W + 1;

   pwbd_pkg::back_state_type        state_ff, state_in;
   logic [ADDR_W-1:0]               head_ff, head_in;
   logic [FILL_W-1:0]               fill_ff, fill_in;
   logic [ADDR_W-1:0]               rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]               idx_ff, idx_in;
   logic [pwbd_pkg::TIME_W-1:0]     thr_ff, thr_in;
   logic [pwbd_pkg::FRAME_W-1:0]    bits_ff, bits_in;
   logic                            out_valid_ff, out_valid_in;
   logic [pwbd_pkg::FRAME_W-1:0]    frame_ff, frame_in;
   logic [pwbd_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [pwbd_pkg::TIME_W-1:0]     thr_out_ff, thr_out_in;

   logic                            wr_en;
   logic [ADDR_W-1:0]               wr_addr;
   logic [pwbd_pkg::TIME_W-1:0]     rd_data;
   logic [SUM_W-1:0]                tail_sum;
   logic [ADDR_W-1:0]               tail_addr;
   logic                            ring_full;
   logic [pwbd_pkg::TIME_W:0]       thr_wide;
   logic [pwbd_pkg::POS_W-1:0]      bit_pos;
   logic [pwbd_pkg::POS_W-1:0]      fill_less;
   logic                            out_free;

   function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] ptr);
      logic [ADDR_W-1:0] nxt;
      if (ptr == ADDR_W'(RING_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + 1'b1;
      end
      return nxt;
   endfunction

   pwbd_ram #(
      .WIDTH (pwbd_pkg::TIME_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (cmd.width),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   assign ring_full = (fill_ff == FILL_W'(RING_DEPTH));
   assign tail_sum  = SUM_W'(head_ff) + SUM_W'(fill_ff);
   assign tail_addr = (tail_sum >= SUM_W'(RING_DEPTH)) ?
                      ADDR_W'(tail_sum - SUM_W'(RING_DEPTH)) : ADDR_W'(tail_sum);
   assign wr_addr   = ring_full ? head_ff : tail_addr;
   assign thr_wide  = {1'b0, rd_data} + {2'b00, rd_data[pwbd_pkg::TIME_W-1:1]};
   assign bit_pos   = pwbd_pkg::POS_W'(idx_ff) - 1'b1;
   assign fill_less = pwbd_pkg::POS_W'(fill_ff) - 1'b1;
   assign out_free  = !out_valid_ff || out_ready;

   assign out_valid        = out_valid_ff;
   assign out_frame_bits   = frame_ff;
   assign out_bit_count    = count_ff;
   assign out_threshold_us = thr_out_ff;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      rd_ptr_in    = rd_ptr_ff;
      idx_in       = idx_ff;
      thr_in       = thr_ff;
      bits_in      = bits_ff;
      out_valid_in = out_valid_ff && !out_ready;
      frame_in     = frame_ff;
      count_in     = count_ff;
      thr_out_in   = thr_out_ff;
      wr_en        = 1'b0;
      cmd_pop      = 1'b0;
      unique case (state_ff)
         pwbd_pkg::S_IDLE: begin
            if (cmd_valid) begin
               if (!cmd.drain) begin
                  wr_en   = 1'b1;
                  cmd_pop = 1'b1;
                  if (ring_full) begin
                     head_in = ptr_inc(head_ff);
                  end else begin
                     fill_in = fill_ff + 1'b1;
                  end
               end else if (fill_ff == '0) begin
                  cmd_pop = 1'b1;
               end else begin
                  rd_ptr_in = head_ff;
                  state_in  = pwbd_pkg::S_LOAD;
               end
            end
         end
         pwbd_pkg::S_LOAD: begin
            rd_ptr_in = ptr_inc(rd_ptr_ff);
            state_in  = pwbd_pkg::S_THR;
         end
         pwbd_pkg::S_THR: begin
            thr_in    = thr_wide[pwbd_pkg::TIME_W] ? '1 : thr_wide[pwbd_pkg::TIME_W-1:0];
            rd_ptr_in = ptr_inc(rd_ptr_ff);
            idx_in    = FILL_W'(1);
            bits_in   = '0;
            state_in  = (fill_ff == FILL_W'(1)) ? pwbd_pkg::S_DONE : pwbd_pkg::S_SCAN;
         end
         pwbd_pkg::S_SCAN: begin
            if ((rd_data < thr_ff) && (bit_pos < pwbd_pkg::FRAME_LIMIT)) begin
               bits_in[bit_pos[pwbd_pkg::COUNT_W-1:0]] = 1'b1;
            end
            rd_ptr_in = ptr_inc(rd_ptr_ff);
            idx_in    = idx_ff + 1'b1;
            if (pwbd_pkg::POS_W'(idx_ff) == fill_less) begin
               state_in = pwbd_pkg::S_DONE;
            end
         end
         pwbd_pkg::S_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               frame_in     = bits_ff;
               count_in     = (fill_less > pwbd_pkg::POS_W'(pwbd_pkg::COUNT_MAX)) ?
                              pwbd_pkg::COUNT_MAX : fill_less[pwbd_pkg::COUNT_W-1:0];
               thr_out_in   = thr_ff;
               head_in      = '0;
               fill_in      = '0;
               cmd_pop      = 1'b1;
               state_in     = pwbd_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pwbd_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pwbd_pkg::S_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff  <= rd_ptr_in;
      idx_ff     <= idx_in;
      thr_ff     <= thr_in;
      bits_ff    <= bits_in;
      frame_ff   <= frame_in;
      count_ff   <= count_in;
      thr_out_ff <= thr_out_in;
   end

endmodule

// ----- design/pulse_width_bit_decoder.sv -----
// ----------------------------------------------------------------------------
// pulse_width_bit_decoder
// Self-calibrating pulse width decoder: high-pulse widths from edge timestamps
// are collected in a ring and a timeout drains the ring into one frame.
//
//   channel   direction   tdata / tuser
//   req_      in          tdata: coarse_ms, timer_count; tuser: action
//   rsp_      out         tdata: frame_bits, bit_count, threshold_us
//   csr_      in          wr_data: timer_reload
//
// an edge is registered in the front; a fall goes on to the back as a width
// a drain runs LOAD, THR, SCAN, DONE, one ring entry a cycle
// a two-entry queue lets the front keep taking edges while the back drains
// reset is synchronous and clears the ring to empty at once
// ----------------------------------------------------------------------------
module pulse_width_bit_decoder #(
   parameter int unsigned RING_DEPTH = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic [15:0]   csr_wr_data,   // timer_reload
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [47:0]   req_tdata,     // coarse_ms[31:0], timer_count[47:32]
   input  logic [1:0]    req_tuser,     // action[1:0]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [103:0]  rsp_tdata      // frame_bits[63:0], bit_count[69:64],
                                        // threshold_us[101:70], zero[103:102]
);

   logic [pwbd_pkg::TIMER_W-1:0]    reload_ff;
   logic                            f_cmd_valid;
   logic                            f_cmd_ready;
   pwbd_pkg::cmd_type               f_cmd;
   logic                            b_cmd_valid;
   logic                            b_cmd_pop;
   pwbd_pkg::cmd_type               b_cmd;
   logic [pwbd_pkg::FRAME_W-1:0]    frame_bits;
   logic [pwbd_pkg::COUNT_W-1:0]    bit_count;
   logic [pwbd_pkg::TIME_W-1:0]     threshold_us;

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff <= pwbd_pkg::RELOAD_RESET;
      end else if (csr_wr_en) begin
         reload_ff <= csr_wr_data;
      end
   end

   pwbd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .timer_reload   (reload_ff),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .in_action      (req_tuser),
      .in_coarse_ms   (req_tdata[31:0]),
      .in_timer_count (req_tdata[47:32]),
      .cmd_valid      (f_cmd_valid),
      .cmd_ready      (f_cmd_ready),
      .cmd            (f_cmd)
   );

   pwbd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_cmd_valid),
      .push_ready (f_cmd_ready),
      .push_cmd   (f_cmd),
      .pop_valid  (b_cmd_valid),
      .pop        (b_cmd_pop),
      .pop_cmd    (b_cmd)
   );

   pwbd_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (b_cmd_valid),
      .cmd              (b_cmd),
      .cmd_pop          (b_cmd_pop),
      .out_valid        (rsp_tvalid),
      .out_ready        (rsp_tready),
      .out_frame_bits   (frame_bits),
      .out_bit_count    (bit_count),
      .out_threshold_us (threshold_us)
   );

   assign rsp_tdata = {2'b00, threshold_us, bit_count, frame_bits};

endmodule

// ----- sim/pulse_width_bit_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// pulse_width_bit_decoder_tb
// Self-checking bench for the pulse width bit decoder. Edge and timeout
// transfers go in on the req_ stream. A scoreboard object keeps its own copy
// of the timestamp, width ring and threshold logic and predicts every decoded
// frame. Each frame on the rsp_ stream is compared field by field, in order.
// A short directed opening covers the first-edge, wrap, saturation,
// threshold-boundary, empty-timeout and ignored-action cases. Four random
// phases follow, each with its own timer reload and idle/stall pattern. Most
// random traffic is well-formed frames, mixed with broken sequences and noise.
// ----------------------------------------------------------------------------
module pulse_width_bit_decoder_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RING_DEPTH  = 64;
   localparam int unsigned QUIET_LIMIT = 5000;

   class frame_scoreboard;
      typedef struct {
         logic [pwbd_pkg::FRAME_W-1:0] bits;
         logic [pwbd_pkg::COUNT_W-1:0] count;
         logic [pwbd_pkg::TIME_W-1:0]  thr;
      } frame_type;

      logic [pwbd_pkg::TIMER_W-1:0] reload;
      logic [pwbd_pkg::TIME_W-1:0]  last_edge;
      bit                           edge_seen;
      logic [pwbd_pkg::TIME_W-1:0]  widths[$];
      frame_type                    expected_frames[$];
      int unsigned                  mismatches;
      int unsigned                  used_items;
      int unsigned                  drained;

      function new();
         reload     = pwbd_pkg::RELOAD_RESET;
         last_edge  = '0;
         edge_seen  = 0;
         mismatches = 0;
         used_items = 0;
         drained    = 0;
      endfunction

      function int unsigned pending();
         return expected_frames.size();
      endfunction

      function void note_request(pwbd_pkg::action_type act,
                                 logic [pwbd_pkg::TIME_W-1:0] ms,
                                 logic [pwbd_pkg::TIMER_W-1:0] cnt);
         logic [pwbd_pkg::TIME_W-1:0] stamp;
         logic [pwbd_pkg::TIME_W:0]   thr_wide;
         frame_type                   f;
         int                          i;
         case (act)
            pwbd_pkg::ACT_RISE, pwbd_pkg::ACT_FALL: begin
               stamp = ms * 32'(pwbd_pkg::US_PER_MS) + (32'(reload) - 32'(cnt));
               if (act == pwbd_pkg::ACT_FALL) begin
                  // full ring drops its oldest width
                  if (widths.size() == RING_DEPTH)
                     void'(widths.pop_front());
                  widths.push_back(edge_seen ? stamp - last_edge : '0);
               end
               last_edge = stamp;
               edge_seen = 1;
               used_items++;
            end
            pwbd_pkg::ACT_TIMEOUT: begin
               if (widths.size() > 0) begin
                  thr_wide = {1'b0, widths[0]} +
                             {2'b0, widths[0][pwbd_pkg::TIME_W-1:1]};
                  f.thr    = thr_wide[pwbd_pkg::TIME_W] ? '1 :
                             thr_wide[pwbd_pkg::TIME_W-1:0];
                  f.bits   = '0;
                  for (i = 1; i < widths.size(); i++) begin
                     if (widths[i] < f.thr && i <= pwbd_pkg::FRAME_W)
                        f.bits[i-1] = 1'b1;
                  end
                  f.count = (widths.size() - 1 > 63) ? pwbd_pkg::COUNT_MAX
                            : pwbd_pkg::COUNT_W'(widths.size() - 1);
                  widths.delete();
                  expected_frames.push_back(f);
                  used_items++;
                  drained++;
               end
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $display("%0t frame %s mismatch: expected %h actual %h",
                     $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_frame(logic [103:0] d);
         frame_type f;
         if (expected_frames.size() == 0) begin
            $display("%0t unexpected frame: expected none actual %h", $time, d);
            mismatches++;
            return;
         end
         f = expected_frames.pop_front();
         compare_field("frame_bits", f.bits, d[63:0]);
         compare_field("bit_count", 64'(f.count), 64'(d[69:64]));
         compare_field("threshold_us", 64'(f.thr), 64'(d[101:70]));
         compare_field("padding", 64'd0, 64'(d[103:102]));
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_wr_en = 1'b0;
   logic [15:0]   csr_wr_data = '0;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [47:0]   req_tdata = '0;     // coarse_ms[31:0], timer_count[47:32]
   logic [1:0]    req_tuser = '0;     // action[1:0]
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [103:0]  rsp_tdata;          // frame_bits, bit_count, threshold_us, zero

   frame_scoreboard sb = new();

   int unsigned tx_idle_pct  = 0;
   int unsigned rx_stall_pct = 0;
   int unsigned tx_burst     = 0;
   int unsigned rx_burst     = 0;
   int unsigned quiet_cycles = 0;

   pulse_width_bit_decoder #(
      .RING_DEPTH (RING_DEPTH)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: check, stall at random, watchdog
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
         sb.check_frame(rsp_tdata);
      if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t no transfer for %0d cycles", $time, quiet_cycles);
         $display("FAIL pulse_width_bit_decoder");
         $finish;
      end
      if (rx_burst > 0) begin
         rx_burst--;
         rsp_tready <= 1'b1;
      end else if ($urandom_range(999) == 0) begin
         rx_burst = $urandom_range(60, 20);
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   task automatic send_item(pwbd_pkg::action_type act, logic [31:0] ms,
                            logic [15:0] cnt);
      int unsigned gap;
      gap = 0;
      if (tx_burst > 0)
         tx_burst--;
      else if ($urandom_range(999) == 0)
         tx_burst = $urandom_range(40, 10);
      else
         while ($urandom_range(99) < tx_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {cnt, ms};
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      sb.note_request(act, ms, cnt);
   endtask

   // picks coarse_ms and timer_count that land exactly on the given timestamp
   task automatic edge_at(pwbd_pkg::action_type act, logic [31:0] stamp);
      int          c;
      logic [31:0] ms;
      c  = int'(sb.reload) - int'(stamp % 1000);
      ms = stamp / 1000;
      if (c < 0) begin
         c += 1000;
         ms++;
      end
      while (c + 1000 <= 65535 && $urandom_range(3) == 0) begin
         c += 1000;
         ms++;
      end
      ms += $urandom_range(7) << 29;
      send_item(act, ms, c[15:0]);
   endtask

   task automatic send_timeout();
      send_item(pwbd_pkg::ACT_TIMEOUT, $urandom, 16'($urandom_range(65535)));
   endtask

   task automatic wait_for_frames();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reload(logic [15:0] value);
      wait_for_frames();
      repeat (20) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.reload = value;
   endtask

   task automatic send_frame();
      int unsigned    nbits;
      int unsigned    r;
      int unsigned    k;
      logic [31:0]    w0;
      logic [31:0]    thr;
      logic [31:0]    w;
      logic [31:0]    t;
      logic [32:0]    thr_wide;
      longint unsigned hi;
      r = $urandom_range(99);
      nbits = r < 85 ? $urandom_range(20, 0) :
              r < 95 ? $urandom_range(62, 21) : $urandom_range(70, 63);
      r = $urandom_range(99);
      w0 = r < 40 ? $urandom_range(60, 0) :
           r < 80 ? $urandom_range(5000, 100) :
           r < 95 ? $urandom_range(2000000, 5000) :
                    $urandom_range(32'hFFFF_FFFF, 32'hAAAA_AAAA);
      thr_wide = {1'b0, w0} + {2'b0, w0[31:1]};
      thr = thr_wide[32] ? '1 : thr_wide[31:0];
      t = sb.last_edge;
      for (k = 0; k <= nbits; k++) begin
         t += $urandom_range(5000, 1);
         edge_at(pwbd_pkg::ACT_RISE, t);
         if (k == 0)
            w = w0;
         else if ($urandom_range(1)) begin
            if (thr == 0)
               w = 0;
            else
               w = $urandom_range(3) == 0 ? thr - 1 : $urandom_range(thr - 1, thr / 2);
         end else begin
            hi = 2 * longint'(thr) + 10;
            if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
            w = $urandom_range(3) == 0 ? thr : $urandom_range(32'(hi), thr);
         end
         t += w;
         edge_at(pwbd_pkg::ACT_FALL, t);
      end
      send_timeout();
   endtask

   task automatic send_broken();
      int unsigned n;
      int unsigned a;
      n = $urandom_range(8, 1);
      repeat (n) begin
         a = $urandom_range(2);
         if (a == 2)
            send_timeout();
         else
            edge_at(pwbd_pkg::action_type'(a), sb.last_edge + $urandom_range(100000));
      end
   endtask

   task automatic send_noise();
      repeat ($urandom_range(4, 1))
         send_item(pwbd_pkg::action_type'($urandom_range(3)), $urandom,
                   16'($urandom_range(65535)));
   endtask

   task automatic random_phase(int unsigned quota, int unsigned min_frames, bit hold);
      int unsigned start_items;
      int unsigned start_frames;
      int unsigned nframes;
      int unsigned r;
      start_items  = sb.used_items;
      start_frames = sb.drained;
      nframes      = 0;
      while (sb.used_items - start_items < quota || sb.drained - start_frames < min_frames)
      begin
         r = $urandom_range(99);
         if (r < 80) begin
            send_frame();
            nframes++;
            // let the decoder run dry now and then
            if (hold && nframes % 5 == 0)
               wait_for_frames();
         end else if (r < 90) begin
            send_broken();
         end else begin
            send_noise();
         end
      end
   endtask

   task automatic directed_part();
      send_item(pwbd_pkg::ACT_TIMEOUT, 32'd0, 16'd0);         // empty ring
      send_item(pwbd_pkg::ACT_NONE, 32'hFFFF_FFFF, 16'hFFFF); // ignored action
      send_item(pwbd_pkg::ACT_FALL, 32'd0, 16'd0);            // first edge, zero width
      edge_at(pwbd_pkg::ACT_RISE, 32'd5000);
      edge_at(pwbd_pkg::ACT_FALL, 32'd55000);
      edge_at(pwbd_pkg::ACT_RISE, 32'd56000);
      edge_at(pwbd_pkg::ACT_FALL, 32'd56000);
      send_timeout();
      send_item(pwbd_pkg::ACT_RISE, 32'd0, 16'd0);
      send_item(pwbd_pkg::ACT_FALL, 32'd0, 16'hFFFF);         // count above reload
      send_item(pwbd_pkg::ACT_RISE, 32'hFFFF_FFFF, 16'd0);
      send_item(pwbd_pkg::ACT_FALL, 32'hFFFF_FFFF, 16'd49990);
      send_item(pwbd_pkg::ACT_RISE, 32'd0, 16'd0);
      send_item(pwbd_pkg::ACT_FALL, 32'd0, 16'd1);            // width of all ones
      send_timeout();                                         // saturated threshold
      edge_at(pwbd_pkg::ACT_RISE, 32'd1_000_000);
      edge_at(pwbd_pkg::ACT_FALL, 32'd1_001_000);
      edge_at(pwbd_pkg::ACT_RISE, 32'd1_010_000);
      edge_at(pwbd_pkg::ACT_FALL, 32'd1_011_499);             // just under threshold
      edge_at(pwbd_pkg::ACT_RISE, 32'd1_020_000);
      edge_at(pwbd_pkg::ACT_FALL, 32'd1_021_500);             // exactly on threshold
      send_item(pwbd_pkg::ACT_NONE, $urandom, 16'($urandom_range(65535)));
      send_timeout();
      send_timeout();
   endtask

   initial begin
      logic [15:0] reloads[4];
      int unsigned p;
      reloads[0] = 16'hFFFF;
      reloads[1] = 16'd1;
      reloads[2] = 16'($urandom_range(65534, 2));
      reloads[3] = 16'd1000;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_part();
      for (p = 0; p < 4; p++) begin
         write_reload(reloads[p]);
         tx_idle_pct  = (p == 1) ? 55 : (p == 3) ? 26 : 0;
         rx_stall_pct = (p == 2) ? 55 : (p == 3) ? 26 : 0;
         random_phase(290, 6, p == 1);
      end
      wait_for_frames();
      repeat (100) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("PASS pulse_width_bit_decoder");
      else
         $display("FAIL pulse_width_bit_decoder");
      $finish;
   end

endmodule

// ----- files.f -----
design/pwbd_pkg.sv
design/pwbd_ram.sv
design/pwbd_front.sv
design/pwbd_queue.sv
design/pwbd_back.sv
design/pulse_width_bit_decoder.sv
sim/pulse_width_bit_decoder_tb.sv
